### hw/rtl/scfr_pkg.sv
package scfr_pkg;

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_MAP    = 3'd1;
    localparam logic [2:0] OP_ACCESS = 3'd2;
    localparam logic [2:0] OP_PIN    = 3'd3;
    localparam logic [2:0] OP_UNPIN  = 3'd4;
    localparam logic [2:0] OP_UNMAP  = 3'd5;
    localparam logic [2:0] OP_FREE   = 3'd6;
    localparam logic [2:0] OP_BAD    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RECL  = 2'd1;
    localparam logic [1:0] ST_NOFRM = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int PAGE_W = 35;
    localparam int SLOT_W = 6;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic decode_res;
        logic fscan_step;
        logic fresh_take;
        logic walk_start;
        logic walk_pos;
        logic walk_run;
        logic acc_clear;
        logic victim_read;
        logic victim_take;
        logic no_frame;
        logic shift_wr;
        logic free_end;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic bad;
        logic full;
        logic free_hit;
        logic q_vld;
        logic q_cand;
        logic q_acc;
        logic q_last;
        logic q_match;
        logic walk_empty;
    } t_stat;

endpackage

### hw/rtl/scfr_dp.sv
module scfr_dp
    import scfr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [2:0]          i_operation,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [PAGE_W-1:0]   i_page_number,
    output logic [1:0]          o_status,
    output logic [SLOT_W-1:0]   o_frame_slot,
    output logic [PAGE_W-1:0]   o_evicted_page
);

    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int LW = $clog2(NUM_FRAMES + 1);

    logic [2:0]            r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [PAGE_W-1:0]     r_page;
    logic [LW-1:0]         r_len;
    logic [NUM_FRAMES-1:0] r_inuse, r_pinned, r_mapped, r_acc;
    logic [LW-1:0]         r_rd_idx;
    logic [LW-1:0]         r_q_idx;
    logic [FW-1:0]         r_q;
    logic                  r_qv;
    logic [FW-1:0]         r_vf;
    logic [PAGE_W-1:0]     r_tq;
    logic [1:0]            r_status;
    logic [SLOT_W-1:0]     r_fslot;
    logic [PAGE_W-1:0]     r_evict;

    logic [FW-1:0]         r_list [NUM_FRAMES];
    logic [PAGE_W-1:0]     r_tag  [NUM_FRAMES];

    logic [FW-1:0] slot_ix;
    logic          slot_ovr;
    logic          bad;
    logic          issue;
    logic          lst_we;
    logic [FW-1:0] lst_wa, lst_wd;
    logic          tag_we;

    assign slot_ix  = FW'(r_slot);
    assign slot_ovr = (int'(r_slot) >= NUM_FRAMES);
    assign bad = (r_op == OP_BAD) || slot_ovr || !r_inuse[slot_ix] ||
                 ((r_op == OP_ACCESS) && !r_mapped[slot_ix]);
    assign issue = i_cmd.walk_run && (r_rd_idx < r_len);

    always_comb begin
        o_stat.is_alloc   = (r_op == OP_ALLOC);
        o_stat.is_free    = (r_op == OP_FREE);
        o_stat.bad        = bad;
        o_stat.full       = (r_len == LW'(NUM_FRAMES));
        o_stat.free_hit   = !r_inuse[FW'(r_rd_idx)];
        o_stat.q_vld      = r_qv;
        o_stat.q_cand     = !r_pinned[r_q] && r_mapped[r_q];
        o_stat.q_acc      = r_acc[r_q];
        o_stat.q_last     = (r_q_idx == LW'(r_len - LW'(1)));
        o_stat.q_match    = (r_q == slot_ix);
        o_stat.walk_empty = !(r_rd_idx < r_len) && !r_qv;
    end

    assign lst_we = i_cmd.fresh_take || i_cmd.shift_wr;
    assign lst_wa = i_cmd.fresh_take ? FW'(r_len) : FW'(LW'(r_q_idx - LW'(1)));
    assign lst_wd = i_cmd.fresh_take ? FW'(r_rd_idx) : r_q;
    assign tag_we = i_cmd.decode_res && !bad && (r_op == OP_MAP);

    // frame order list: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (lst_we) begin
            r_list[lst_wa] <= lst_wd;
        end
        if (issue) begin
            r_q <= r_list[FW'(r_rd_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag[slot_ix] <= r_page;
        end
        if (i_cmd.victim_read) begin
            r_tq <= r_tag[r_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_slot <= i_slot;
            r_page <= i_page_number;
        end
        if (issue) begin
            r_q_idx <= r_rd_idx;
        end
        if (i_cmd.victim_read) begin
            r_vf <= r_q;
        end
        if (i_cmd.decode_res) begin
            r_status <= bad ? ST_BAD : ST_OK;
            r_fslot  <= r_slot;
            r_evict  <= '0;
        end
        if (i_cmd.fresh_take) begin
            r_status <= ST_OK;
            r_fslot  <= SLOT_W'(r_rd_idx);
            r_evict  <= '0;
        end
        if (i_cmd.victim_take) begin
            r_status <= ST_RECL;
            r_fslot  <= SLOT_W'(r_vf);
            r_evict  <= r_tq;
        end
        if (i_cmd.no_frame) begin
            r_status <= ST_NOFRM;
            r_fslot  <= '0;
            r_evict  <= '0;
        end
        if (i_cmd.free_end) begin
            r_status <= ST_OK;
            r_fslot  <= r_slot;
            r_evict  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_inuse  <= '0;
            r_pinned <= '0;
            r_mapped <= '0;
            r_acc    <= '0;
            r_rd_idx <= '0;
            r_qv     <= 1'b0;
        end else begin
            if (i_cmd.walk_start) begin
                r_rd_idx <= i_cmd.walk_pos ? LW'(r_q_idx + LW'(1)) : '0;
                r_qv     <= 1'b0;
            end else if (i_cmd.fscan_step) begin
                r_rd_idx <= LW'(r_rd_idx + LW'(1));
            end else if (i_cmd.walk_run) begin
                r_qv <= issue;
                if (issue) begin
                    r_rd_idx <= LW'(r_rd_idx + LW'(1));
                end
            end

            if (i_cmd.decode_res && !bad) begin
                case (r_op)
                    OP_MAP: begin
                        r_mapped[slot_ix] <= 1'b1;
                        r_acc[slot_ix]    <= 1'b0;
                    end
                    OP_ACCESS: r_acc[slot_ix]    <= 1'b1;
                    OP_PIN:    r_pinned[slot_ix] <= 1'b1;
                    OP_UNPIN:  r_pinned[slot_ix] <= 1'b0;
                    OP_UNMAP: begin
                        r_mapped[slot_ix] <= 1'b0;
                        r_acc[slot_ix]    <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.fresh_take) begin
                r_inuse[FW'(r_rd_idx)]  <= 1'b1;
                r_pinned[FW'(r_rd_idx)] <= 1'b0;
                r_mapped[FW'(r_rd_idx)] <= 1'b0;
                r_acc[FW'(r_rd_idx)]    <= 1'b0;
                r_len <= LW'(r_len + LW'(1));
            end
            if (i_cmd.acc_clear) begin
                r_acc[r_q] <= 1'b0;
            end
            if (i_cmd.victim_take) begin
                r_mapped[r_vf] <= 1'b0;
                r_acc[r_vf]    <= 1'b0;
            end
            if (i_cmd.free_end) begin
                r_inuse[slot_ix]  <= 1'b0;
                r_pinned[slot_ix] <= 1'b0;
                r_mapped[slot_ix] <= 1'b0;
                r_acc[slot_ix]    <= 1'b0;
                r_len <= LW'(r_len - LW'(1));
            end
        end
    end

    assign o_status       = r_status;
    assign o_frame_slot   = r_fslot;
    assign o_evicted_page = r_evict;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_len) <= NUM_FRAMES)
        else $error("order list longer than frame table");

    // the number of in-use frames equals the order list length
    a_len_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_inuse) == int'(r_len))
        else $error("in-use count differs from list length");

    a_acc_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & ~r_mapped) == '0)
        else $error("accessed mark on unmapped frame");

endmodule

### hw/rtl/scfr_ctrl.sv
module scfr_ctrl
    import scfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output logic  o_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FSCAN,
        S_VSCAN,
        S_VTAKE,
        S_USCAN,
        S_SHIFT,
        S_FEND
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   r_any, n_any;
    logic   r_busy;
    logic   r_valid, n_valid;
    logic   any_now;

    assign any_now = r_any || i_stat.q_cand;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_pass  = r_pass;
        n_any   = r_any;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_alloc) begin
                    o_cmd.walk_start = 1'b1;
                    n_pass = 1'b0;
                    n_any  = 1'b0;
                    n_state = i_stat.full ? S_VSCAN : S_FSCAN;
                end else if (i_stat.is_free && !i_stat.bad) begin
                    o_cmd.walk_start = 1'b1;
                    n_state = S_USCAN;
                end else begin
                    o_cmd.decode_res = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FSCAN: begin
                if (i_stat.free_hit) begin
                    o_cmd.fresh_take = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.fscan_step = 1'b1;
                end
            end
            S_VSCAN: begin
                if (i_stat.q_vld && i_stat.q_cand && !i_stat.q_acc) begin
                    o_cmd.victim_read = 1'b1;
                    n_state = S_VTAKE;
                end else begin
                    // second chance: clear the mark and pass over
                    o_cmd.acc_clear = i_stat.q_vld && i_stat.q_cand;
                    if (i_stat.q_vld && i_stat.q_last) begin
                        if (!r_pass && any_now) begin
                            o_cmd.walk_start = 1'b1;
                            n_pass = 1'b1;
                            n_any  = 1'b0;
                        end else begin
                            o_cmd.no_frame = 1'b1;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.walk_run = 1'b1;
                        if (i_stat.q_vld && i_stat.q_cand) begin
                            n_any = 1'b1;
                        end
                    end
                end
            end
            S_VTAKE: begin
                o_cmd.victim_take = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_USCAN: begin
                if (i_stat.q_vld && i_stat.q_match) begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.walk_pos   = 1'b1;
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.walk_run = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.walk_empty) begin
                    n_state = S_FEND;
                end else begin
                    o_cmd.walk_run = 1'b1;
                    o_cmd.shift_wr = i_stat.q_vld;
                end
            end
            S_FEND: begin
                o_cmd.free_end = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_any   <= 1'b0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_any   <= n_any;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy out of step with state");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transfer did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

endmodule

### hw/rtl/second_chance_frame_replacer.sv
// Second-chance frame replacer. A request is taken when start is high and busy is low; its
// result appears on o_status/o_frame_slot/o_evicted_page for one cycle with o_valid and
// cannot be held off. Map, access, pin, unpin, unmap, a free of a bad frame and bad requests
// are settled in the decode state, from which o_valid is registered. An allocate with a free
// frame checks the frames from 0 upward, one frame per cycle, and takes the lowest free one.
// An eviction walks the allocation-order memory one entry per cycle and may make two passes.
// A free looks up the frame's place in the order memory and then shifts the tail down one
// entry per cycle.
module second_chance_frame_replacer
    import scfr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [PAGE_W-1:0] i_page_number,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_frame_slot,
    output logic [PAGE_W-1:0] o_evicted_page
);

    t_cmd  cmd;
    t_stat stat;

    scfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scfr_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_page_number  (i_page_number),
        .o_status       (o_status),
        .o_frame_slot   (o_frame_slot),
        .o_evicted_page (o_evicted_page)
    );

endmodule
